/* design/rmq_pkg.sv */
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int N_IN      = 9;
    localparam int N_Q       = 4;

    // positive radicand, its scaled form and the root
    localparam int R_W    = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam int SUM_W  = R_W + 2;
    localparam int RAD_W  = R_W + FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int S_W    = ROOT_W + 1;

    // numerator magnitude, scaled dividend and quotient (divisor >= 2^(F/2+1))
    localparam int N_W    = 17;
    localparam int DIV_W  = N_W + FRAC_BITS;
    localparam int QUO_W  = DIV_W - (FRAC_BITS / 2 + 1);

    typedef logic [1:0] t_case;
    localparam t_case CASE_TRACE = 2'd0;
    localparam t_case CASE_X     = 2'd1;
    localparam t_case CASE_Y     = 2'd2;
    localparam t_case CASE_Z     = 2'd3;

    typedef logic [1:0] t_lane;
    localparam t_lane LANE_X = 2'd0;
    localparam t_lane LANE_Y = 2'd1;
    localparam t_lane LANE_Z = 2'd2;
    localparam t_lane LANE_W = 2'd3;

    typedef struct packed {
        logic                      vld;
        t_case                     sel;
        logic                      degen;
        logic [N_Q-1:0]            neg;
        logic [N_Q-1:0][N_W-1:0]   mag;
        logic [ROOT_W-1:0]         root;
    } t_sb;

    // lane that takes its value straight from the root
    function automatic t_lane root_lane(input t_case sel);
        t_lane l;
        case (sel)
            CASE_TRACE: l = LANE_W;
            CASE_X:     l = LANE_X;
            CASE_Y:     l = LANE_Y;
            CASE_Z:     l = LANE_Z;
            default:    l = LANE_W;
        endcase
        return l;
    endfunction

endpackage

/* design/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion (Shepperd's method), Q2.14 fixed point.
// Input channel (i_s_*): one beat carries the nine matrix entries m00..m22,
// row major, 16 bits signed each. Output channel (o_m_*): one beat per input
// beat with qx, qy, qz, qw (16 bits signed, saturated) in tdata and the
// branch taken plus a degenerate flag in tuser.
// Pipeline from input beat to output beat: one stage forms the trace, branch,
// radicand and the off-diagonal sums, 16 stages of digit-by-digit square root,
// one stage forms dividend and divisor, 23 stages of restoring division (four
// lanes side by side) and one output register.
// Throughput: one beat per cycle unless the receiver stalls; every stage of the
// root and the divider is its own register, so a new matrix may enter each cycle.
// Reset (synchronous, active low) clears every valid bit; data registers
// keep whatever they hold. When the receiver stalls with a result waiting,
// the whole pipeline holds and o_s_tready drops; bubbles travel with it and
// nothing is lost or repeated. A radicand of zero or less gives zeros and
// degenerate set; case_taken still names the branch.
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  logic [143:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // qx, qy, qz, qw from bit 0 up
    output logic [63:0]   o_m_tdata,
    // case_taken [1:0], degenerate [2]
    output logic [2:0]    o_m_tuser
);

    localparam int IW   = rmq_pkg::IN_W;
    localparam int OW   = rmq_pkg::OUT_W;
    localparam int SUMW = rmq_pkg::SUM_W;
    localparam int NQ   = rmq_pkg::N_Q;
    localparam int NW   = rmq_pkg::N_W;
    localparam int FB   = rmq_pkg::FRAC_BITS;
    localparam int QW   = rmq_pkg::QUO_W;
    localparam int RTW  = rmq_pkg::ROOT_W;
    localparam int DW   = rmq_pkg::DIV_W;
    localparam int SB_N = RTW + QW + 2;
    localparam int PREP = RTW + 1;
    localparam logic signed [SUMW-1:0] ONE_S = SUMW'(1) << FB;
    localparam logic signed [OW:0]     QMAX  = (OW+1)'((1 << (OW - 1)) - 1);

    logic w_ce;

    // ---- input stage: trace, branch, radicand and numerators ----
    logic signed [SUMW-1:0] w_e [rmq_pkg::N_IN];
    logic signed [SUMW-1:0] w_trace, w_r;
    logic signed [SUMW-1:0] w_nv [NQ];
    logic signed [SUMW-1:0] w_abs;
    rmq_pkg::t_sb           n_sb0;
    logic [rmq_pkg::RAD_W-1:0] n_rad;

    always_comb begin
        for (int i = 0; i < rmq_pkg::N_IN; i++) begin
            w_e[i] = SUMW'(signed'(i_s_tdata[i*IW +: IW]));
        end
    end

    // entry indices: 0 m00, 1 m01, 2 m02, 3 m10, 4 m11, 5 m12, 6 m20, 7 m21, 8 m22
    always_comb begin
        w_trace = w_e[0] + w_e[4] + w_e[8];
        n_sb0   = '0;
        for (int i = 0; i < NQ; i++) begin
            w_nv[i] = '0;
        end
        if (w_trace > 0) begin
            n_sb0.sel = rmq_pkg::CASE_TRACE;
            w_r       = w_trace + ONE_S;
            w_nv[0]   = w_e[7] - w_e[5];
            w_nv[1]   = w_e[2] - w_e[6];
            w_nv[2]   = w_e[3] - w_e[1];
        end else if (w_e[0] > w_e[4] && w_e[0] > w_e[8]) begin
            n_sb0.sel = rmq_pkg::CASE_X;
            w_r       = ONE_S + w_e[0] - w_e[4] - w_e[8];
            w_nv[3]   = w_e[7] - w_e[5];
            w_nv[1]   = w_e[1] + w_e[3];
            w_nv[2]   = w_e[2] + w_e[6];
        end else if (w_e[4] > w_e[8]) begin
            n_sb0.sel = rmq_pkg::CASE_Y;
            w_r       = ONE_S + w_e[4] - w_e[0] - w_e[8];
            w_nv[3]   = w_e[2] - w_e[6];
            w_nv[0]   = w_e[1] + w_e[3];
            w_nv[2]   = w_e[5] + w_e[7];
        end else begin
            n_sb0.sel = rmq_pkg::CASE_Z;
            w_r       = ONE_S + w_e[8] - w_e[0] - w_e[4];
            w_nv[3]   = w_e[3] - w_e[1];
            w_nv[0]   = w_e[2] + w_e[6];
            w_nv[1]   = w_e[5] + w_e[7];
        end
        n_sb0.vld   = i_s_tvalid;
        n_sb0.degen = w_r[SUMW-1] | (w_r == '0);
        w_abs       = '0;
        for (int i = 0; i < NQ; i++) begin
            n_sb0.neg[i] = w_nv[i][SUMW-1];
            w_abs        = w_nv[i][SUMW-1] ? -w_nv[i] : w_nv[i];
            n_sb0.mag[i] = w_abs[NW-1:0];
        end
        // feed zero on a degenerate item; its outputs are forced to zero
        n_rad = n_sb0.degen ? '0 : {w_r[rmq_pkg::R_W-1:0], FB'(0)};
    end

    // ---- sideband line: valid, branch, signs, magnitudes, root ----
    rmq_pkg::t_sb r_sb [SB_N];
    rmq_pkg::t_sb n_sb_prep;
    logic [rmq_pkg::RAD_W-1:0] r_rad;
    logic [RTW-1:0]            w_root;

    always_comb begin
        n_sb_prep      = r_sb[PREP-1];
        n_sb_prep.root = w_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SB_N; i++) begin
                r_sb[i].vld <= 1'b0;
            end
        end else if (w_ce) begin
            r_sb[0] <= n_sb0;
            for (int i = 1; i < SB_N; i++) begin
                if (i == PREP) begin
                    r_sb[i] <= n_sb_prep;
                end else begin
                    r_sb[i] <= r_sb[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_rad <= n_rad;
        end
    end

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // ---- dividend n*ONE + s/2 and divisor s = 2*root ----
    logic [NQ-1:0][DW-1:0]        r_num;
    logic [rmq_pkg::S_W-1:0]      r_den;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_den <= {w_root, 1'b0};
            for (int l = 0; l < NQ; l++) begin
                r_num[l] <= {r_sb[PREP-1].mag[l], FB'(0)} + DW'(w_root);
            end
        end
    end

    logic [NQ-1:0][QW-1:0] w_quo;

    rmq_div u_div (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (w_quo)
    );

    // ---- sign, saturate, root lane, degenerate zeroing ----
    rmq_pkg::t_sb              w_fin;
    rmq_pkg::t_lane            w_big;
    logic [NQ-1:0][OW-1:0]     n_q;
    logic [NQ-1:0][OW-1:0]     r_q;
    logic                      r_out_vld;
    rmq_pkg::t_case            r_sel;
    logic                      r_degen;

    assign w_fin = r_sb[SB_N-1];
    assign w_big = rmq_pkg::root_lane(w_fin.sel);

    always_comb begin
        for (int l = 0; l < NQ; l++) begin
            if (w_fin.degen) begin
                n_q[l] = '0;
            end else if (w_big == rmq_pkg::t_lane'(l)) begin
                n_q[l] = OW'(w_fin.root >> 1);
            end else if (!w_fin.neg[l]) begin
                n_q[l] = (QW'(w_quo[l]) > QW'(QMAX)) ? QMAX[OW-1:0] : w_quo[l][OW-1:0];
            end else if (QW'(w_quo[l]) > QW'(QMAX + 1)) begin
                n_q[l] = {1'b1, {(OW-1){1'b0}}};
            end else begin
                n_q[l] = -w_quo[l][OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_fin.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_q     <= n_q;
            r_sel   <= w_fin.sel;
            r_degen <= w_fin.degen;
        end
    end

    // advance everything unless a result waits on a stalled receiver
    assign w_ce       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_ce;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_q;
    assign o_m_tuser  = {r_degen, r_sel};

endmodule

/* design/rmq_sqrt.sv */
module rmq_sqrt (
    input  logic                           i_clk,
    input  logic                           i_ce,
    input  logic [rmq_pkg::RAD_W-1:0]      i_rad,
    output logic [rmq_pkg::ROOT_W-1:0]     o_root
);

    localparam int RW = rmq_pkg::RAD_W;
    localparam int QW = rmq_pkg::ROOT_W;

    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [RW-1:0] w_rem;
        logic [QW-1:0] w_root;
        logic [RW:0]   w_trial;

        if (j == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign w_trial = ((RW+1)'(w_root) << (K + 1)) + ((RW+1)'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if ({1'b0, w_rem} >= w_trial) begin
                    r_rem[j]  <= w_rem - w_trial[RW-1:0];
                    r_root[j] <= w_root | (QW'(1) << K);
                end else begin
                    r_rem[j]  <= w_rem;
                    r_root[j] <= w_root;
                end
            end
        end
    end

    assign o_root = r_root[QW-1];

endmodule

/* design/rmq_div.sv */
module rmq_div (
    input  logic                                              i_clk,
    input  logic                                              i_ce,
    input  logic [rmq_pkg::N_Q-1:0][rmq_pkg::DIV_W-1:0]       i_num,
    input  logic [rmq_pkg::S_W-1:0]                           i_den,
    output logic [rmq_pkg::N_Q-1:0][rmq_pkg::QUO_W-1:0]       o_quo
);

    localparam int NQ = rmq_pkg::N_Q;
    localparam int DW = rmq_pkg::DIV_W;
    localparam int QW = rmq_pkg::QUO_W;
    localparam int SW = rmq_pkg::S_W;
    localparam int TW = SW + QW;

    logic [NQ-1:0][DW-1:0] r_rem [QW];
    logic [NQ-1:0][QW-1:0] r_quo [QW];
    logic [SW-1:0]         r_den [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [NQ-1:0][DW-1:0] w_rem;
        logic [NQ-1:0][QW-1:0] w_quo;
        logic [SW-1:0]         w_den;
        logic [TW-1:0]         w_trial;

        if (j == 0) begin : g_first
            assign w_rem = i_num;
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_quo = r_quo[j-1];
            assign w_den = r_den[j-1];
        end

        assign w_trial = TW'(w_den) << K;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_den[j] <= w_den;
                for (int l = 0; l < NQ; l++) begin
                    if (TW'(w_rem[l]) >= w_trial) begin
                        r_rem[j][l] <= w_rem[l] - w_trial[DW-1:0];
                        r_quo[j][l] <= w_quo[l] | (QW'(1) << K);
                    end else begin
                        r_rem[j][l] <= w_rem[l];
                        r_quo[j][l] <= w_quo[l];
                    end
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* verif/rotation_matrix_to_quaternion_tb.sv */
module rotation_matrix_to_quaternion_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE       = 1 << rmq_pkg::FRAC_BITS;
    localparam int N_RANDOM  = 1100;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 60;

    typedef struct packed {
        logic [15:0]    qx;
        logic [15:0]    qy;
        logic [15:0]    qz;
        logic [15:0]    qw;
        rmq_pkg::t_case sel;
        logic           degen;
    } t_quat;

    typedef struct {
        logic [143:0] mat;
        logic         typed;
        t_quat        quat;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    logic [143:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // qx, qy, qz, qw from bit 0 up
    logic [63:0]  o_m_tdata;
    // case_taken [1:0], degenerate [2]
    logic [2:0]   o_m_tuser;

    t_quat pending_quats[$];
    int    n_errors;
    int    cycle_count;
    int    send_idle_pct;
    int    recv_stall_pct;
    t_row  directed[$];

    rotation_matrix_to_quaternion uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root by bisection; radicands here stay well under 2^40.
    function automatic longint isqrt(input longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 1 << 21;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // n * ONE / s, round half away from zero
    function automatic longint quot_round(input longint n, input longint s);
        longint mag;
        mag = ((n < 0) ? -n : n) * ONE;
        mag = (mag + (s >> 1)) / s;
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic t_quat shepperd(input logic [143:0] mat);
        longint a[9];
        longint nm[4];
        longint trace, rad, root, s;
        int     big;
        t_quat  q;
        for (int k = 0; k < 9; k++) a[k] = longint'($signed(mat[16*k +: 16]));
        for (int k = 0; k < 4; k++) nm[k] = 0;
        trace = a[0] + a[4] + a[8];
        if (trace > 0) begin
            q.sel = rmq_pkg::CASE_TRACE; rad = trace + ONE; big = 3;
            nm[0] = a[7] - a[5]; nm[1] = a[2] - a[6]; nm[2] = a[3] - a[1];
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            q.sel = rmq_pkg::CASE_X; rad = ONE + a[0] - a[4] - a[8]; big = 0;
            nm[3] = a[7] - a[5]; nm[1] = a[1] + a[3]; nm[2] = a[2] + a[6];
        end else if (a[4] > a[8]) begin
            q.sel = rmq_pkg::CASE_Y; rad = ONE + a[4] - a[0] - a[8]; big = 1;
            nm[3] = a[2] - a[6]; nm[0] = a[1] + a[3]; nm[2] = a[5] + a[7];
        end else begin
            q.sel = rmq_pkg::CASE_Z; rad = ONE + a[8] - a[0] - a[4]; big = 2;
            nm[3] = a[3] - a[1]; nm[0] = a[2] + a[6]; nm[1] = a[5] + a[7];
        end
        q.degen = (rad <= 0);
        q.qx = '0; q.qy = '0; q.qz = '0; q.qw = '0;
        if (rad > 0) begin
            root = isqrt(rad * ONE);
            s = 2 * root;
            for (int k = 0; k < 4; k++) begin
                nm[k] = (k == big) ? (root >> 1) : quot_round(nm[k], s);
            end
            q.qx = clamp16(nm[0]); q.qy = clamp16(nm[1]);
            q.qz = clamp16(nm[2]); q.qw = clamp16(nm[3]);
        end
        return q;
    endfunction

    function automatic logic [143:0] pack_mat(input int e[9]);
        logic [143:0] m;
        for (int k = 0; k < 9; k++) m[16*k +: 16] = e[k][15:0];
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
        n_errors++;
    endtask

    // Compare each output beat against the oldest outstanding quaternion.
    always @(posedge i_clk) begin
        t_quat want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                   o_m_tdata[63:48], o_m_tuser[1:0], o_m_tuser[2]};
            if (pending_quats.size() == 0) begin
                $display("unexpected output beat at cycle %0d", cycle_count);
                n_errors++;
            end else begin
                want = pending_quats.pop_front();
                if (got.qx !== want.qx) report_mismatch("qx", got.qx, want.qx);
                if (got.qy !== want.qy) report_mismatch("qy", got.qy, want.qy);
                if (got.qz !== want.qz) report_mismatch("qz", got.qz, want.qz);
                if (got.qw !== want.qw) report_mismatch("qw", got.qw, want.qw);
                if (got.sel !== want.sel)
                    report_mismatch("case_taken", 16'(got.sel), 16'(want.sel));
                if (got.degen !== want.degen)
                    report_mismatch("degenerate", 16'(got.degen), 16'(want.degen));
            end
        end
    end

    // Stall the receiver at the phase's rate, redrawn every cycle.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold one beat on the bus until accepted, with random idle cycles before it.
    task automatic send_beat(input logic [143:0] mat);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= mat;
        pending_quats.push_back(shepperd(mat));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic add_row(input int e[9], input logic typed, input t_quat q);
        t_row r;
        r.mat = pack_mat(e);
        r.typed = typed;
        r.quat = q;
        directed.push_back(r);
    endtask

    // Random matrix; some modes push one diagonal entry up to favour a branch.
    function automatic logic [143:0] random_mat();
        int e[9];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 9; k++) begin
            if (mode < 6) e[k] = $urandom_range(32768) - 16384;
            else e[k] = $urandom_range(65535) - 32768;
        end
        if (mode < 6 && mode >= 2) begin
            // push one diagonal entry up to favour the x, y or z branch
            e[4 * (mode - 2 < 3 ? mode - 2 : 0)] = $urandom_range(16384);
        end
        if (mode == 9) begin
            for (int k = 0; k < 9; k++) e[k] = $urandom_range(1) ? 32767 : -32768;
        end
        return pack_mat(e);
    endfunction

    initial begin
        int    e[9];
        t_quat q;
        t_quat none;
        none = '0;
        n_errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b1;

        // identity: w = 1, others zero
        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        q = '{16'd0, 16'd0, 16'd0, 16'd16384, rmq_pkg::CASE_TRACE, 1'b0};
        add_row(e, 1'b1, q);
        // all zero: trace not positive, tie falls to z, radicand ONE
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        q = '{16'd0, 16'd0, 16'd8192, 16'd0, rmq_pkg::CASE_Z, 1'b0};
        add_row(e, 1'b1, q);
        // large diagonal entries, one row in each branch (trace, z, x, y)
        e = '{0, 0, 0, 0, 32767, 0, 0, 0, 32767};
        add_row(e, 1'b0, none);
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        add_row(e, 1'b0, none);
        e = '{-16384, 0, 0, 0, -32768, 0, 0, 0, -32768};
        add_row(e, 1'b0, none);
        e = '{-32768, 0, 0, 0, -16384, 0, 0, 0, -32768};
        add_row(e, 1'b0, none);
        // 180 degree turns about x, y, z
        e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
        add_row(e, 1'b0, none);
        e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
        add_row(e, 1'b0, none);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
        add_row(e, 1'b0, none);
        // extreme off-diagonals to drive saturation
        e = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
        add_row(e, 1'b0, none);
        e = '{-32768, 32767, 32767, 32767, -32767, 32767, 32767, 32767, -32768};
        add_row(e, 1'b0, none);
        e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        add_row(e, 1'b0, none);
        e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        add_row(e, 1'b0, none);
        // 90 degree turn about z
        e = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};
        add_row(e, 1'b0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_beat(directed[k].mat);
            if (directed[k].typed) pending_quats[pending_quats.size() - 1] = directed[k].quat;
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            case ((4 * n) / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            send_beat(random_mat());
        end
        i_s_tvalid <= 1'b0;

        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
